// ----- rtl/core/scba_pkg.sv -----
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, constants and table functions for the size-class allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

	localparam int unsigned PAGE_SHIFT  = 12;
	localparam int unsigned PAGE_BYTES  = 4096;
	localparam int unsigned MAX_REQUEST = 2048;
	localparam int unsigned MAX_CLASSES = 8;
	localparam int unsigned CLASS_W     = 3;
	localparam int unsigned WORD_BITS   = 64;
	localparam int unsigned BIT_W       = 6;
	localparam int unsigned WORDS       = 8;
	localparam int unsigned WORD_W      = 3;
	localparam int unsigned POS_W       = 9;
	localparam int unsigned CNT_W       = 9;
	localparam int unsigned ADDR_W      = 48;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_CLASS = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_SRCH,
		S_CLR,
		S_FIN
	} state_t;

	// One access of the bitmap memory: a read, a write, or neither.
	typedef struct packed {
		logic                 rd_en;
		logic [WORD_W-1:0]    rd_word;
		logic                 wr_en;
		logic [WORD_W-1:0]    wr_word;
		logic [WORD_BITS-1:0] wr_data;
	} bm_req_t;

	// Chunks per page for a class; zero when the chunk is larger than a page.
	function automatic int unsigned cls_count(int unsigned min_shift, int unsigned c);
		int unsigned sh;
		sh = min_shift + c;
		return (sh <= PAGE_SHIFT) ? (32'd1 << (PAGE_SHIFT - sh)) : 32'd0;
	endfunction

	// First bitmap position of a class: the classes below it are packed first.
	function automatic int unsigned cls_offset(int unsigned min_shift, int unsigned c);
		int unsigned off;
		off = 0;
		for (int unsigned k = 0; k < c; k++) begin
			off = off + cls_count(min_shift, k);
		end
		return off;
	endfunction

endpackage

// ----- rtl/core/scba_if.sv -----
// ----------------------------------------------------------------------------
// scba channel interfaces
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface scba_req_if;
	logic              valid;
	logic              ready;
	scba_pkg::opcode_t opcode;
	logic [15:0]       request_size;
	logic [15:0]       free_address;

	modport source(output valid, opcode, request_size, free_address, input ready);
	modport sink(input valid, opcode, request_size, free_address, output ready);
endinterface

interface scba_rsp_if;
	logic              valid;
	logic              ready;
	scba_pkg::status_t status;
	logic [47:0]       chunk_address;

	modport source(output valid, status, chunk_address, input ready);
	modport sink(input valid, status, chunk_address, output ready);
endinterface

interface scba_cfg_if;
	logic        valid;
	logic        ready;
	logic [47:0] region_base;

	modport source(output valid, region_base, input ready);
	modport sink(input valid, region_base, output ready);
endinterface

// ----- rtl/core/size_class_bitmap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator_top
// Slab allocator with power-of-two size classes, one page each, tracked by
// an occupancy bitmap held in a small synchronous memory.
//
//   channel | dir | payload                               | transfer when
//   --------+-----+---------------------------------------+------------------
//   cfg     | in  | region_base                           | valid && ready
//   req     | in  | opcode, request_size, free_address    | valid && ready
//   rsp     | out | status, chunk_address                 | valid && ready
//
// An allocate decodes, scans the bitmap words of its class (one word per
// cycle through the memory read port, up to 4 for the smallest class) and
// finishes; a rejected request skips the scan and a free clears its bit.
// One request is in flight at a time; the response register lets the next
// request enter while the previous response waits for its transfer.
// Reset clears the bitmap at once through per-word valid flags; cfg is
// always ready.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator_top #(
	parameter int unsigned NUM_CLASSES     = 8,
	parameter int unsigned MIN_CHUNK_BYTES = 16
) (
	input logic        clk,
	input logic        arst_n,
	scba_cfg_if.sink   cfg,
	scba_req_if.sink   req,
	scba_rsp_if.source rsp
);
	import scba_pkg::*;

	localparam int unsigned MIN_SHIFT    = $clog2(MIN_CHUNK_BYTES);
	localparam int unsigned TOP_CHUNK    = MIN_CHUNK_BYTES << (NUM_CLASSES - 1);
	localparam int unsigned SIZE_LIMIT_I = (TOP_CHUNK > MAX_REQUEST) ? MAX_REQUEST : TOP_CHUNK;
	localparam logic [15:0] SIZE_LIMIT   = 16'(SIZE_LIMIT_I);

	// Per-class constant tables.
	logic [16:0]      chunk_tbl [MAX_CLASSES];
	logic [CNT_W-1:0] cnt_tbl   [MAX_CLASSES];
	logic [POS_W-1:0] off_tbl   [MAX_CLASSES];
	logic [3:0]       shift_tbl [MAX_CLASSES];

	for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_tbl
		assign chunk_tbl[g] = 17'(MIN_CHUNK_BYTES << g);
		assign cnt_tbl[g]   = CNT_W'(cls_count(MIN_SHIFT, g));
		assign off_tbl[g]   = POS_W'(cls_offset(MIN_SHIFT, g));
		assign shift_tbl[g] = 4'(MIN_SHIFT + g);
	end

	state_t state_q, state_d;

	logic [ADDR_W-1:0]    region_base_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [ADDR_W-1:0]    out_addr_q;

	opcode_t              op_q;
	logic [15:0]          size_q;
	logic [15:0]          faddr_q;
	logic [CLASS_W-1:0]   cls_q;
	logic [WORD_W-1:0]    word_q;
	logic [WORD_W-1:0]    last_q;
	logic [WORD_BITS-1:0] mask_q;
	logic [BIT_W-1:0]     bit_q;
	logic [POS_W-1:0]     pos_q;
	status_t              status_q;

	bm_req_t              bm_req;
	logic [WORD_BITS-1:0] rd_data;

	scba_bitmap_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.bm_req  (bm_req),
		.rd_data (rd_data)
	);

	// ---------------- decode of the captured request ----------------
	logic [CLASS_W-1:0]   alloc_cls;
	logic [CLASS_W-1:0]   cls_d;
	logic                 too_large;
	logic                 free_bad;
	logic [CNT_W-1:0]     cnt_d;
	logic [POS_W-1:0]     off_d;
	logic [3:0]           sh_d;
	logic [11:0]          free_idx;
	logic                 free_hit;
	logic [POS_W-1:0]     free_pos;
	logic [POS_W-1:0]     last_pos;
	logic [WORD_BITS-1:0] mask_d;
	status_t              status_d;
	logic                 dec_goes_on;

	always_comb begin
		alloc_cls = '0;
		for (int c = int'(NUM_CLASSES) - 1; c >= 0; c--) begin
			if ({1'b0, size_q} <= chunk_tbl[c]) begin
				alloc_cls = CLASS_W'(c);
			end
		end
		too_large = size_q > SIZE_LIMIT;
		free_bad  = faddr_q[15:12] >= 4'(NUM_CLASSES);
		cls_d     = (op_q == OP_ALLOC) ? alloc_cls : faddr_q[14:12];
		cnt_d     = cnt_tbl[cls_d];
		off_d     = off_tbl[cls_d];
		sh_d      = shift_tbl[cls_d];
		// Rounding down to a chunk drops the low offset bits.
		free_idx  = faddr_q[11:0] >> sh_d;
		free_hit  = free_idx < 12'(cnt_d);
		free_pos  = off_d + free_idx[POS_W-1:0];
		last_pos  = off_d + cnt_d - POS_W'(1);
		// Small classes share a word; large ones fill whole words.
		if (cnt_d >= CNT_W'(WORD_BITS)) begin
			mask_d = '1;
		end else begin
			mask_d = ((64'd1 << cnt_d) - 64'd1) << off_d[BIT_W-1:0];
		end
		if (op_q == OP_ALLOC) begin
			if (too_large) begin
				status_d    = ST_TOO_LARGE;
				dec_goes_on = 1'b0;
			end else if (cnt_d == '0) begin
				status_d    = ST_FULL;
				dec_goes_on = 1'b0;
			end else begin
				status_d    = ST_OK;
				dec_goes_on = 1'b1;
			end
		end else begin
			status_d    = free_bad ? ST_BAD_CLASS : ST_OK;
			dec_goes_on = !free_bad && free_hit;
		end
	end

	// ---------------- search of one bitmap word ----------------
	logic [WORD_BITS-1:0] cand;
	logic                 found;
	logic [BIT_W-1:0]     hit;

	always_comb begin
		cand  = ~rd_data & mask_q;
		found = |cand;
		hit   = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit = BIT_W'(b);
			end
		end
	end

	// ---------------- address of the granted chunk ----------------
	logic [POS_W-1:0]  chunk_idx;
	logic [23:0]       page_off_full;
	logic [ADDR_W-1:0] grant_addr;
	logic              alloc_ok;

	always_comb begin
		chunk_idx     = pos_q - off_tbl[cls_q];
		page_off_full = {15'b0, chunk_idx} << shift_tbl[cls_q];
		grant_addr    = region_base_q + {33'b0, cls_q, page_off_full[11:0]};
		alloc_ok      = (op_q == OP_ALLOC) && (status_q == ST_OK);
	end

	logic out_free;
	logic load_out;
	assign out_free = !out_valid_q || rsp.ready;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req.valid) state_d = S_DEC;
			S_DEC: begin
				if (!dec_goes_on) begin
					state_d = S_FIN;
				end else begin
					state_d = (op_q == OP_ALLOC) ? S_SRCH : S_CLR;
				end
			end
			S_SRCH: if (found || word_q == last_q) state_d = S_FIN;
			S_CLR:  state_d = S_FIN;
			S_FIN:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- state outputs ----------------
	always_comb begin
		req.ready = 1'b0;
		load_out  = 1'b0;
		bm_req    = '0;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_DEC: begin
				bm_req.rd_en   = dec_goes_on;
				bm_req.rd_word = (op_q == OP_ALLOC) ? off_d[POS_W-1:BIT_W]
				                                    : free_pos[POS_W-1:BIT_W];
			end
			S_SRCH: begin
				if (found) begin
					bm_req.wr_en   = 1'b1;
					bm_req.wr_word = word_q;
					bm_req.wr_data = rd_data | (64'd1 << hit);
				end else if (word_q != last_q) begin
					bm_req.rd_en   = 1'b1;
					bm_req.rd_word = word_q + WORD_W'(1);
				end
			end
			S_CLR: begin
				bm_req.wr_en   = 1'b1;
				bm_req.wr_word = word_q;
				bm_req.wr_data = rd_data & ~(64'd1 << bit_q);
			end
			S_FIN: load_out = out_free;
			default: ;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			region_base_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				region_base_q <= cfg.region_base;
			end
		end
	end

	assign cfg.ready         = 1'b1;
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.chunk_address = out_addr_q;

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_q    <= req.opcode;
					size_q  <= req.request_size;
					faddr_q <= req.free_address;
				end
			end
			S_DEC: begin
				cls_q    <= cls_d;
				mask_q   <= mask_d;
				last_q   <= last_pos[POS_W-1:BIT_W];
				word_q   <= (op_q == OP_ALLOC) ? off_d[POS_W-1:BIT_W]
				                               : free_pos[POS_W-1:BIT_W];
				bit_q    <= free_pos[BIT_W-1:0];
				status_q <= status_d;
			end
			S_SRCH: begin
				if (found) begin
					pos_q <= {word_q, hit};
				end else if (word_q == last_q) begin
					status_q <= ST_FULL;
				end else begin
					word_q <= word_q + WORD_W'(1);
				end
			end
			S_FIN: begin
				if (load_out) begin
					out_status_q <= status_q;
					out_addr_q   <= alloc_ok ? grant_addr : '0;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// A response appears only as the last step of a request.
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_FIN))
		else $error("response raised outside the finish step");

	// The memory never reads and writes in the same cycle.
	a_ram_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(bm_req.rd_en && bm_req.wr_en))
		else $error("bitmap read and write in one cycle");

	// The scan never walks past the last word of the class.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (word_q <= last_q))
		else $error("bitmap scan beyond its class");

	// Failed requests never carry an address.
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.chunk_address == '0))
		else $error("address on a failed response");
`endif

endmodule

// ----- rtl/core/scba_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// scba_bitmap_ram
// Occupancy bitmap: eight 64-bit words, one registered read port and one
// write port. A word never written since reset reads as all free.
// ----------------------------------------------------------------------------
module scba_bitmap_ram (
	input  logic                                clk,
	input  logic                                arst_n,
	input  scba_pkg::bm_req_t                   bm_req,
	output logic [scba_pkg::WORD_BITS-1:0]      rd_data
);
	import scba_pkg::*;

	logic [WORD_BITS-1:0] mem_q [WORDS];
	logic [WORDS-1:0]     valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (bm_req.wr_en) begin
			valid_q[bm_req.wr_word] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bm_req.wr_en) begin
			mem_q[bm_req.wr_word] <= bm_req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (bm_req.rd_en) begin
			rd_data <= valid_q[bm_req.rd_word] ? mem_q[bm_req.rd_word] : '0;
		end
	end

endmodule

// ----- tb/scba_outcome_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scba_outcome_checker
// Watches the configuration, request and response channels of the size-class
// allocator. It keeps its own occupancy map and region base, works out the
// outcome of every accepted request, and compares each response transfer
// field by field with the oldest outcome still waiting.
// ----------------------------------------------------------------------------
module scba_outcome_checker #(
	parameter int unsigned NUM_CLASSES     = 8,
	parameter int unsigned MIN_CHUNK_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	scba_cfg_if         cfg,
	scba_req_if         req,
	scba_rsp_if         rsp,
	output int          fail_count,
	output int unsigned pending
);
	import scba_pkg::*;

	localparam int unsigned MAP_BITS = 512;

	typedef struct packed {
		status_t     status;
		logic [47:0] chunk_address;
	} outcome_t;

	logic [47:0]         region_base;
	bit [MAP_BITS-1:0]   occupied;
	outcome_t            outcome_q[$];
	outcome_t            want;

	function automatic int unsigned chunk_size(int unsigned c);
		return MIN_CHUNK_BYTES << c;
	endfunction

	// A class whose chunk is larger than a page holds nothing.
	function automatic int unsigned chunks_in_page(int unsigned c);
		return PAGE_BYTES / chunk_size(c);
	endfunction

	// Classes are packed into the map in order, smallest chunk first.
	function automatic int unsigned first_bit(int unsigned c);
		int unsigned sum;
		sum = 0;
		for (int unsigned k = 0; k < c; k++) begin
			sum += chunks_in_page(k);
		end
		return sum;
	endfunction

	function automatic outcome_t serve_request(opcode_t op, logic [15:0] size,
	                                           logic [15:0] addr);
		outcome_t    o;
		int unsigned limit;
		int unsigned c;
		int unsigned i;
		int unsigned cnt;
		int unsigned pos;
		int unsigned base_pos;
		bit          found;
		o.status        = ST_OK;
		o.chunk_address = '0;
		found           = 1'b0;
		if (op == OP_ALLOC) begin
			limit = chunk_size(NUM_CLASSES - 1);
			if (limit > MAX_REQUEST)
				limit = MAX_REQUEST;
			if (size > limit) begin
				o.status = ST_TOO_LARGE;
			end else begin
				c = 0;
				while (c < NUM_CLASSES - 1 && size > chunk_size(c))
					c++;
				cnt      = chunks_in_page(c);
				base_pos = first_bit(c);
				i        = 0;
				while (i < cnt && !found) begin
					pos = base_pos + i;
					if (pos < MAP_BITS && !occupied[pos]) begin
						occupied[pos] = 1'b1;
						found         = 1'b1;
					end else begin
						i++;
					end
				end
				if (!found)
					o.status = ST_FULL;
				else
					o.chunk_address = region_base + 48'(c * PAGE_BYTES + i * chunk_size(c));
			end
		end else begin
			c = addr[15:12];
			if (c >= NUM_CLASSES) begin
				o.status = ST_BAD_CLASS;
			end else begin
				// An unaligned address rounds down to the chunk that holds it.
				i   = addr[11:0] / chunk_size(c);
				pos = first_bit(c) + i;
				if (i < chunks_in_page(c) && pos < MAP_BITS)
					occupied[pos] = 1'b0;
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] wanted);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, wanted);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base = '0;
			occupied    = '0;
			outcome_q.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				region_base = cfg.region_base;
			if (req.valid && req.ready)
				outcome_q.push_back(serve_request(req.opcode, req.request_size,
				                                  req.free_address));
			if (rsp.valid && rsp.ready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("response with nothing outstanding",
					                rsp.chunk_address, '0);
				end else begin
					want = outcome_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 48'(rsp.status), 48'(want.status));
					if (rsp.chunk_address !== want.chunk_address)
						report_mismatch("chunk_address", rsp.chunk_address,
						                want.chunk_address);
				end
			end
			pending = outcome_q.size();
		end
	end

endmodule

// ----- tb/tb_size_class_bitmap_allocator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_size_class_bitmap_allocator_top
// Drives the size-class allocator with a directed set of corner requests and
// then phases of random allocate and free traffic under changing region
// bases and flow-control patterns. Checking is done by the outcome checker.
// ----------------------------------------------------------------------------
module tb_size_class_bitmap_allocator_top;
	import scba_pkg::*;

	localparam int unsigned NUM_CLASSES     = 8;
	localparam int unsigned MIN_CHUNK_BYTES = 16;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned QUIET_LIMIT     = 5000;
	localparam int unsigned SETTLE_CYCLES   = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          send_idle = 0;
	int          rsp_stall = 0;
	bit          hold_rsp = 1'b0;
	int          fail_count;
	int unsigned pending;

	scba_cfg_if cfg();
	scba_req_if req();
	scba_rsp_if rsp();

	size_class_bitmap_allocator_top #(
		.NUM_CLASSES(NUM_CLASSES),
		.MIN_CHUNK_BYTES(MIN_CHUNK_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

	scba_outcome_checker #(
		.NUM_CLASSES(NUM_CLASSES),
		.MIN_CHUNK_BYTES(MIN_CHUNK_BYTES)
	) outcome_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// Offers one request and returns at the edge where it transfers. Valid
	// stays high afterwards so that back-to-back requests need no toggle.
	task automatic send_item(opcode_t op, logic [15:0] size, logic [15:0] addr);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle) begin
			req.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.request_size <= size;
		req.free_address <= addr;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain_requests();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_region_base(logic [47:0] value);
		@(negedge clk);
		cfg.valid       <= 1'b1;
		cfg.region_base <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_pacing(int idle_pct, int stall_pct);
		@(posedge clk);
		send_idle = idle_pct;
		rsp_stall = stall_pct;
	endtask

	// Mostly well-formed allocates and frees around one class of interest,
	// with a little raw noise that also reaches oversize and bad-class cases.
	task automatic random_item(int alloc_pct, int unsigned focus);
		int unsigned c;
		int unsigned chunk;
		int unsigned cnt;
		int unsigned idx;
		logic [15:0] addr;
		if ($urandom_range(0, 99) < 6) begin
			send_item(opcode_t'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
		end else begin
			c     = ($urandom_range(0, 99) < 60) ? focus : $urandom_range(0, NUM_CLASSES - 1);
			chunk = MIN_CHUNK_BYTES << c;
			cnt   = PAGE_BYTES / chunk;
			if ($urandom_range(0, 99) < alloc_pct) begin
				if (c == 0)
					send_item(OP_ALLOC, 16'($urandom_range(0, chunk)), 16'($urandom));
				else
					send_item(OP_ALLOC, 16'($urandom_range(chunk / 2 + 1, chunk)),
					          16'($urandom));
			end else begin
				// Low indexes are the ones most likely to be in use.
				if ($urandom_range(0, 99) < 70)
					idx = $urandom_range(0, (cnt > 32) ? 31 : cnt - 1);
				else
					idx = $urandom_range(0, cnt - 1);
				addr = 16'(c << PAGE_SHIFT) | 16'(idx * chunk);
				if ($urandom_range(0, 3) == 0)
					addr = addr | 16'($urandom_range(0, chunk - 1));
				send_item(OP_FREE, 16'($urandom), addr);
			end
		end
	endtask

	task automatic run_phase(int n, int alloc_pct, int unsigned focus);
		repeat (n) random_item(alloc_pct, focus);
	endtask

	// Response side: random stalls, plus one long hold-off on request.
	initial begin
		rsp.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= rsp_stall);
			end
		end
	end

	// Ends the run if no transfer of any kind happens for too long.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
			    (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** size_class_bitmap_allocator_top: FAILED **");
		$finish;
	end

	initial begin
		cfg.valid        = 1'b0;
		cfg.region_base  = '0;
		req.valid        = 1'b0;
		req.opcode       = OP_ALLOC;
		req.request_size = '0;
		req.free_address = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		write_region_base(48'h0);
		set_pacing(0, 0);

		// Corner requests, starting from an empty map.
		send_item(OP_ALLOC, 16'd0, 16'h0000);
		send_item(OP_ALLOC, 16'd1, 16'h0000);
		send_item(OP_ALLOC, 16'd16, 16'h0000);
		send_item(OP_ALLOC, 16'd17, 16'h0000);
		send_item(OP_ALLOC, 16'd2048, 16'h0000);
		send_item(OP_ALLOC, 16'd2048, 16'h0000);
		send_item(OP_ALLOC, 16'd2000, 16'h0000);
		send_item(OP_ALLOC, 16'd2049, 16'h0000);
		send_item(OP_ALLOC, 16'hFFFF, 16'h0000);
		send_item(OP_FREE, 16'h0000, 16'h7000);
		send_item(OP_FREE, 16'h0000, 16'h7FFF);
		send_item(OP_FREE, 16'h0000, 16'h7000);
		send_item(OP_ALLOC, 16'd1025, 16'h0000);
		send_item(OP_FREE, 16'h0000, 16'h8000);
		send_item(OP_FREE, 16'hFFFF, 16'hFFFF);
		send_item(OP_FREE, 16'hFFFF, 16'h0010);
		send_item(OP_ALLOC, 16'd5, 16'hFFFF);
		send_item(OP_FREE, 16'h0000, 16'h6C00);
		send_item(OP_ALLOC, 16'd512, 16'h0000);
		send_item(OP_ALLOC, 16'd256, 16'h0000);
		send_item(OP_ALLOC, 16'd128, 16'h0000);
		send_item(OP_ALLOC, 16'd64, 16'h0000);
		send_item(OP_ALLOC, 16'd32, 16'h0000);
		send_item(OP_FREE, 16'h0000, 16'h0000);
		drain_requests();

		// Highest base: chunk addresses wrap around the top of the space.
		write_region_base(48'hFFFF_FFFF_FFFF);
		set_pacing(0, 0);
		run_phase(150, 85, 0);
		drain_requests();

		write_region_base(48'({$urandom, $urandom}) & 48'hFFFF_FFFF_0000);
		set_pacing(77, 0);
		run_phase(130, 90, 1);
		drain_requests();

		// Long response hold-off while requests keep coming, so the block
		// backs up and stops accepting.
		write_region_base(48'hFFFF_FFFF_0000);
		set_pacing(0, 77);
		run_phase(20, 90, 1);
		hold_rsp = 1'b1;
		run_phase(110, 90, 1);
		drain_requests();

		write_region_base(48'({$urandom, $urandom}));
		set_pacing(31, 31);
		run_phase(70, 40, 2);
		drain_requests();
		run_phase(70, 40, 0);
		drain_requests();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** size_class_bitmap_allocator_top: PASSED **");
		else
			$display("** size_class_bitmap_allocator_top: FAILED **");
		$finish;
	end

endmodule
